>>> rtl/wsc_pkg.sv
// ----------------------------------------------------------------------------
// wsc_pkg: shared types and constants for the two-channel window statistics
// sample widths, the default window length and the control struct
// ----------------------------------------------------------------------------
package wsc_pkg;

  // default window length, legal range 2 to 64
  localparam int WSC_WINDOW_LEN = 8;

  // raw field widths
  localparam int WSC_RAW_W  = 16;
  localparam int WSC_VOLT_W = 13;
  localparam int WSC_CUR_W  = 16;

  // bus register word holds the reading above three status bits
  localparam int WSC_VOLT_SHIFT = 3;

  // start values for the running extremes
  localparam logic [WSC_VOLT_W-1:0]       WSC_VOLT_ALL_ONES = 13'h1FFF;
  localparam logic [WSC_VOLT_W-1:0]       WSC_VOLT_ZERO     = 13'h0000;
  localparam logic signed [WSC_CUR_W-1:0] WSC_CUR_MOST_NEG  = 16'sh8000;
  localparam logic signed [WSC_CUR_W-1:0] WSC_CUR_MOST_POS  = 16'sh7FFF;

  // window storage control from the sequencer
  typedef struct packed {
    logic push;    // shift a new sample in, oldest drops out
    logic rotate;  // move the oldest entry back to the newest slot
  } wsc_win_ctrl_t;

endpackage : wsc_pkg

>>> rtl/wsc_if.sv
// ----------------------------------------------------------------------------
// wsc_if: valid/ready channels of the window statistics block
// one interface for raw samples and one for statistics results
// ----------------------------------------------------------------------------
interface wsc_in_if;
  logic                valid;
  logic                ready;
  logic [15:0]         bus_voltage_raw;
  logic signed [15:0]  shunt_raw;

  modport source (output valid, output bus_voltage_raw, output shunt_raw, input ready);
  modport sink   (input valid, input bus_voltage_raw, input shunt_raw, output ready);
endinterface : wsc_in_if

interface wsc_out_if;
  logic                valid;
  logic                ready;
  logic [12:0]         volt_max;
  logic [12:0]         volt_min;
  logic [12:0]         volt_mean;
  logic signed [15:0]  cur_max;
  logic signed [15:0]  cur_min;
  logic signed [15:0]  cur_mean;

  modport source (output valid, output volt_max, output volt_min, output volt_mean,
                  output cur_max, output cur_min, output cur_mean, input ready);
  modport sink   (input valid, input volt_max, input volt_min, input volt_mean,
                  input cur_max, input cur_min, input cur_mean, output ready);
endinterface : wsc_out_if

>>> rtl/wsc_window.sv
// ----------------------------------------------------------------------------
// wsc_window: sample windows for both channels
// a shift line per channel; the oldest tap is read and fed back on rotate
// ----------------------------------------------------------------------------
module wsc_window
  import wsc_pkg::*;
#(
  parameter int WINDOW_LEN = WSC_WINDOW_LEN
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  wsc_win_ctrl_t               ctrl_i,
  input  logic [WSC_VOLT_W-1:0]       volt_i,
  input  logic signed [WSC_CUR_W-1:0] cur_i,
  output logic [WSC_VOLT_W-1:0]       volt_tap_o,
  output logic signed [WSC_CUR_W-1:0] cur_tap_o
);

  logic [WSC_VOLT_W-1:0]       volt_q [WINDOW_LEN];
  logic signed [WSC_CUR_W-1:0] cur_q  [WINDOW_LEN];
  logic [WSC_VOLT_W-1:0]       volt_head;
  logic signed [WSC_CUR_W-1:0] cur_head;
  logic                        shift_en;

  // oldest entry sits at the far end of the line
  assign volt_tap_o = volt_q[WINDOW_LEN-1];
  assign cur_tap_o  = cur_q[WINDOW_LEN-1];

  // new sample on push, recirculated oldest entry on rotate
  assign volt_head = ctrl_i.push ? volt_i : volt_q[WINDOW_LEN-1];
  assign cur_head  = ctrl_i.push ? cur_i  : cur_q[WINDOW_LEN-1];
  assign shift_en  = ctrl_i.push | ctrl_i.rotate;

  // shift line, cleared to zero samples at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        volt_q[i] <= '0;
        cur_q[i]  <= '0;
      end
    end else if (shift_en) begin
      volt_q[0] <= volt_head;
      cur_q[0]  <= cur_head;
      for (int i = 1; i < WINDOW_LEN; i++) begin
        volt_q[i] <= volt_q[i-1];
        cur_q[i]  <= cur_q[i-1];
      end
    end
  end

endmodule : wsc_window

>>> rtl/wsc_divider.sv
// ----------------------------------------------------------------------------
// wsc_divider: shared unsigned divider by the window length
// multiply by the rounded-up reciprocal in a registered product, shared by
// the voltage and current means
// ----------------------------------------------------------------------------
module wsc_divider
  import wsc_pkg::*;
#(
  parameter int WINDOW_LEN = WSC_WINDOW_LEN,
  parameter int DIV_W      = WSC_CUR_W + $clog2(WINDOW_LEN)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quotient_o
);

  // q = (n * ceil(2^(DIV_W+l) / len)) >> (DIV_W+l), exact for n < 2^DIV_W
  localparam int LEN_W  = $clog2(WINDOW_LEN);
  localparam int SHIFT  = DIV_W + LEN_W;
  localparam int MUL_W  = DIV_W + 1;
  localparam int PROD_W = DIV_W + MUL_W;
  localparam longint unsigned RecipFull =
    ((64'd1 << SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
  localparam logic [MUL_W-1:0] RecipVal = MUL_W'(RecipFull);

  logic [PROD_W-1:0] prod_q;
  logic              done_q;

  // control state: done and quotient valid in the cycle after start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  // reciprocal product
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= PROD_W'(dividend_i) * PROD_W'(RecipVal);
    end
  end

  assign done_o     = done_q;
  assign quotient_o = DIV_W'(prod_q >> SHIFT);

endmodule : wsc_divider

>>> rtl/window_stats_two_channel.sv
// ----------------------------------------------------------------------------
// window_stats_two_channel: moving-window max, min and mean of two channels
// bus voltage and shunt samples each enter a window; stats of both windows
// are produced once per sample
// ----------------------------------------------------------------------------
//  channel | dir | handshake    | payload
//  in_i    | in  | valid/ready  | bus_voltage_raw[15:0], shunt_raw[15:0] signed
//  res_o   | out | valid/ready  | volt_max/min/mean[12:0], cur_max/min/mean[15:0]
//
//  a transaction runs through the accept state, the walk over the window one
//  entry per cycle, the voltage mean and then the current mean in the shared
//  reciprocal multiplier, and the result state.
//  in_i.ready is high only while idle; a result waits in its registers until
//  res_o.ready, and the next sample is taken after the result leaves.
//  reset clears both windows to zero samples at once; no clearing pass.
// ----------------------------------------------------------------------------
module window_stats_two_channel
  import wsc_pkg::*;
#(
  parameter int WINDOW_LEN = WSC_WINDOW_LEN
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wsc_in_if.sink     in_i,
  wsc_out_if.source  res_o
);

  localparam int LEN_W  = $clog2(WINDOW_LEN);
  localparam int VSUM_W = WSC_VOLT_W + LEN_W;
  localparam int CSUM_W = WSC_CUR_W + LEN_W;
  localparam int DIV_W  = CSUM_W;
  localparam logic [LEN_W-1:0] LastTap = LEN_W'(WINDOW_LEN - 1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_VDIV = 3'd2;
  localparam logic [2:0] S_CDIV = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]                  state_q, state_d;
  logic [LEN_W-1:0]            cnt_q, cnt_d;
  wsc_win_ctrl_t               win_ctrl;
  logic [WSC_VOLT_W-1:0]       volt_in, volt_tap;
  logic signed [WSC_CUR_W-1:0] cur_tap;
  logic                        in_fire, out_fire, last_tap;

  logic [WSC_VOLT_W-1:0]       vmax_q, vmax_d, vmin_q, vmin_d, vmean_q, vmean_d;
  logic signed [WSC_CUR_W-1:0] cmax_q, cmax_d, cmin_q, cmin_d, cmean_q, cmean_d;
  logic [VSUM_W-1:0]           vsum_q, vsum_d;
  logic signed [CSUM_W-1:0]    csum_q, csum_d;
  logic                        cneg_q, cneg_d;

  logic                        div_start, div_done;
  logic [DIV_W-1:0]            div_dividend, div_quotient, cur_mag;
  logic [WSC_CUR_W-1:0]        cur_quo;

  assign in_fire  = in_i.valid & in_i.ready;
  assign out_fire = res_o.valid & res_o.ready;
  assign last_tap = (cnt_q == LastTap);
  assign volt_in  = WSC_VOLT_W'(in_i.bus_voltage_raw >> WSC_VOLT_SHIFT);

  // magnitude of the current sum for the unsigned divider
  assign cur_mag = csum_q[CSUM_W-1] ? DIV_W'(-csum_q) : DIV_W'(csum_q);
  assign cur_quo = WSC_CUR_W'(div_quotient);

  // window storage
  assign win_ctrl.push   = in_fire;
  assign win_ctrl.rotate = (state_q == S_SCAN);

  wsc_window #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (win_ctrl),
    .volt_i     (volt_in),
    .cur_i      (in_i.shunt_raw),
    .volt_tap_o (volt_tap),
    .cur_tap_o  (cur_tap)
  );

  // divider start: voltage sum on the last entry of the walk, current magnitude after that
  always_comb begin
    div_start    = 1'b0;
    div_dividend = cur_mag;
    if ((state_q == S_SCAN) && last_tap) begin
      div_start    = 1'b1;
      div_dividend = DIV_W'(vsum_d);
    end else if ((state_q == S_VDIV) && div_done) begin
      div_start = 1'b1;
    end
  end

  wsc_divider #(
    .WINDOW_LEN (WINDOW_LEN),
    .DIV_W      (DIV_W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  // sequencer and running statistics
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    vmax_d  = vmax_q;
    vmin_d  = vmin_q;
    vmean_d = vmean_q;
    cmax_d  = cmax_q;
    cmin_d  = cmin_q;
    cmean_d = cmean_q;
    vsum_d  = vsum_q;
    csum_d  = csum_q;
    cneg_d  = cneg_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_SCAN;
          cnt_d   = '0;
          vmax_d  = WSC_VOLT_ZERO;
          vmin_d  = WSC_VOLT_ALL_ONES;
          cmax_d  = WSC_CUR_MOST_NEG;
          cmin_d  = WSC_CUR_MOST_POS;
          vsum_d  = '0;
          csum_d  = '0;
        end
      end
      S_SCAN: begin
        // one window entry per cycle through the compare/add unit
        if (volt_tap > vmax_q) vmax_d = volt_tap;
        if (volt_tap < vmin_q) vmin_d = volt_tap;
        if (cur_tap > cmax_q)  cmax_d = cur_tap;
        if (cur_tap < cmin_q)  cmin_d = cur_tap;
        vsum_d = vsum_q + VSUM_W'(volt_tap);
        csum_d = csum_q + CSUM_W'(cur_tap);
        cnt_d  = cnt_q + 1'b1;
        if (last_tap) state_d = S_VDIV;
      end
      S_VDIV: begin
        if (div_done) begin
          vmean_d = WSC_VOLT_W'(div_quotient);
          cneg_d  = csum_q[CSUM_W-1];
          state_d = S_CDIV;
        end
      end
      S_CDIV: begin
        // truncation toward zero: divide the magnitude, restore the sign
        if (div_done) begin
          cmean_d = cneg_q ? -$signed(cur_quo) : $signed(cur_quo);
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_fire) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // statistics and result registers
  always_ff @(posedge clk_i) begin
    vmax_q  <= vmax_d;
    vmin_q  <= vmin_d;
    vmean_q <= vmean_d;
    cmax_q  <= cmax_d;
    cmin_q  <= cmin_d;
    cmean_q <= cmean_d;
    vsum_q  <= vsum_d;
    csum_q  <= csum_d;
    cneg_q  <= cneg_d;
  end

  // channel outputs
  assign in_i.ready      = (state_q == S_IDLE);
  assign res_o.valid     = (state_q == S_OUT);
  assign res_o.volt_max  = vmax_q;
  assign res_o.volt_min  = vmin_q;
  assign res_o.volt_mean = vmean_q;
  assign res_o.cur_max   = cmax_q;
  assign res_o.cur_min   = cmin_q;
  assign res_o.cur_mean  = cmean_q;

endmodule : window_stats_two_channel

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: regression for the two-channel moving-window statistics block
// a directed table covers the extremes, signed ordering and truncation of
// negative means; a random run follows. every statistics transaction is
// checked field by field against typed table rows or a window model kept inside this bench
// ----------------------------------------------------------------------------
module tb_top
  import wsc_pkg::*;
();

  localparam int WIN        = WSC_WINDOW_LEN;
  localparam int N_RANDOM   = 1600;
  localparam int IDLE_PCT   = 12;
  localparam int HOLD_LEN   = 400;
  localparam int HOLD_AT    = 200;
  localparam int CALM_FIRST = 500;
  localparam int CALM_LAST  = 800;
  localparam int DRAIN_AT   = 100;
  localparam int TAIL_LEN   = 200;
  localparam int STUCK_MAX  = 3000;

  // sign bias of random shunt samples
  typedef enum logic [1:0] {
    BIAS_NONE,
    BIAS_NEG,
    BIAS_POS
  } sign_bias_e;

  // one statistics transaction
  typedef struct packed {
    logic [WSC_VOLT_W-1:0]        vmax;
    logic [WSC_VOLT_W-1:0]        vmin;
    logic [WSC_VOLT_W-1:0]        vmean;
    logic signed [WSC_CUR_W-1:0]  cmax;
    logic signed [WSC_CUR_W-1:0]  cmin;
    logic signed [WSC_CUR_W-1:0]  cmean;
  } stats_t;

  // one row of the directed table
  typedef struct packed {
    logic [WSC_RAW_W-1:0]         bus;
    logic signed [WSC_RAW_W-1:0]  shunt;
    logic                         typed;
    stats_t                       want;
  } dir_row_t;

  localparam stats_t NO_STATS = '0;

  logic clk_i;
  logic rst_ni;

  wsc_in_if  smp_if ();
  wsc_out_if stat_if ();

  window_stats_two_channel #(
    .WINDOW_LEN (WIN)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (smp_if),
    .res_o  (stat_if)
  );

  // model state: newest sample in slot 0
  logic [WSC_VOLT_W-1:0]       volt_win [WIN];
  logic signed [WSC_CUR_W-1:0] cur_win  [WIN];

  stats_t stats_due [$];
  int     mismatch_cnt = 0;
  int     n_results    = 0;
  bit     calm_tx      = 1'b0;
  bit     held_off     = 1'b0;

  // directed table: typed rows can be read straight off the window contents
  dir_row_t dir_rows [25] = '{
    // first sample after reset, rest of the window still zero
    '{16'h0000, 16'sh0000, 1'b1, '{13'd0, 13'd0, 13'd0, 16'sd0, 16'sd0, 16'sd0}},
    '{16'hFFFF, 16'sh7FFF, 1'b1,
      '{13'd8191, 13'd0, 13'd1023, 16'sh7FFF, 16'sd0, 16'sd4095}},
    // status bits only; most negative shunt, sum -1 truncates to zero
    '{16'h0007, 16'sh8000, 1'b1,
      '{13'd8191, 13'd0, 13'd1023, 16'sh7FFF, 16'sh8000, 16'sd0}},
    '{16'hFFF8, 16'shFFFF, 1'b0, NO_STATS},
    // fill the window with top voltage and most negative current
    '{16'hFFFF, 16'sh8000, 1'b0, NO_STATS},
    '{16'hFFFF, 16'sh8000, 1'b0, NO_STATS},
    '{16'hFFFF, 16'sh8000, 1'b0, NO_STATS},
    '{16'hFFFF, 16'sh8000, 1'b0, NO_STATS},
    '{16'hFFFF, 16'sh8000, 1'b0, NO_STATS},
    '{16'hFFFF, 16'sh8000, 1'b0, NO_STATS},
    '{16'hFFFF, 16'sh8000, 1'b0, NO_STATS},
    '{16'hFFFF, 16'sh8000, 1'b1,
      '{13'd8191, 13'd8191, 13'd8191, 16'sh8000, 16'sh8000, 16'sh8000}},
    // then flip to zero voltage and most positive current
    '{16'h0000, 16'sh7FFF, 1'b0, NO_STATS},
    '{16'h0000, 16'sh7FFF, 1'b0, NO_STATS},
    '{16'h0000, 16'sh7FFF, 1'b0, NO_STATS},
    '{16'h0000, 16'sh7FFF, 1'b0, NO_STATS},
    '{16'h0000, 16'sh7FFF, 1'b0, NO_STATS},
    '{16'h0000, 16'sh7FFF, 1'b0, NO_STATS},
    '{16'h0000, 16'sh7FFF, 1'b0, NO_STATS},
    '{16'h0000, 16'sh7FFF, 1'b1,
      '{13'd0, 13'd0, 13'd0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF}},
    // small values around zero and alternating bit patterns
    '{16'h0008, 16'shFFFF, 1'b0, NO_STATS},
    '{16'h0010, 16'shFFFE, 1'b0, NO_STATS},
    '{16'h5555, 16'sh5555, 1'b0, NO_STATS},
    '{16'hAAAA, 16'shAAAA, 1'b0, NO_STATS},
    '{16'h1234, 16'sh8001, 1'b0, NO_STATS}
  };

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // push one sample pair into the model windows and return the window stats
  function automatic stats_t push_and_stats(input logic [WSC_RAW_W-1:0] bus,
                                            input logic signed [WSC_RAW_W-1:0] shunt);
    stats_t                      s;
    logic [WSC_VOLT_W-1:0]       vmax;
    logic [WSC_VOLT_W-1:0]       vmin;
    logic signed [WSC_CUR_W-1:0] cmax;
    logic signed [WSC_CUR_W-1:0] cmin;
    int                          vsum;
    int                          csum;
    for (int i = WIN - 1; i > 0; i--) begin
      volt_win[i] = volt_win[i-1];
      cur_win[i]  = cur_win[i-1];
    end
    volt_win[0] = bus[WSC_RAW_W-1:WSC_VOLT_SHIFT];
    cur_win[0]  = shunt;
    vmax = WSC_VOLT_ZERO;
    vmin = WSC_VOLT_ALL_ONES;
    cmax = WSC_CUR_MOST_NEG;
    cmin = WSC_CUR_MOST_POS;
    vsum = 0;
    csum = 0;
    for (int i = 0; i < WIN; i++) begin
      if (volt_win[i] > vmax) vmax = volt_win[i];
      if (volt_win[i] < vmin) vmin = volt_win[i];
      if (cur_win[i] > cmax) cmax = cur_win[i];
      if (cur_win[i] < cmin) cmin = cur_win[i];
      vsum += int'(volt_win[i]);
      csum += int'(cur_win[i]);
    end
    s.vmax  = vmax;
    s.vmin  = vmin;
    s.vmean = WSC_VOLT_W'(vsum / WIN);
    s.cmax  = cmax;
    s.cmin  = cmin;
    // int division truncates toward zero
    s.cmean = WSC_CUR_W'(csum / WIN);
    return s;
  endfunction

  // offer one sample transaction, record its stats once it is taken
  task automatic send_sample(input logic [WSC_RAW_W-1:0] bus,
                             input logic signed [WSC_RAW_W-1:0] shunt,
                             input logic typed, input stats_t want);
    stats_t got;
    if (!calm_tx && $urandom_range(99) < IDLE_PCT) begin
      smp_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    smp_if.valid           <= 1'b1;
    smp_if.bus_voltage_raw <= bus;
    smp_if.shunt_raw       <= shunt;
    do @(posedge clk_i); while (!smp_if.ready);
    got = push_and_stats(bus, shunt);
    stats_due.push_back(typed ? want : got);
  endtask

  function automatic void check_field(input string name, input int want, input int seen);
    if (want != seen) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
      mismatch_cnt++;
    end
  endfunction

  task automatic check_stats();
    stats_t want;
    if (stats_due.size() == 0) begin
      $display("%0t: stats transaction with none expected, volt_max %0d cur_max %0d",
               $time, stat_if.volt_max, $signed(stat_if.cur_max));
      mismatch_cnt++;
    end else begin
      want = stats_due.pop_front();
      check_field("volt_max",  int'(want.vmax),  int'(stat_if.volt_max));
      check_field("volt_min",  int'(want.vmin),  int'(stat_if.volt_min));
      check_field("volt_mean", int'(want.vmean), int'(stat_if.volt_mean));
      check_field("cur_max",  int'($signed(want.cmax)),  int'($signed(stat_if.cur_max)));
      check_field("cur_min",  int'($signed(want.cmin)),  int'($signed(stat_if.cur_min)));
      check_field("cur_mean", int'($signed(want.cmean)), int'($signed(stat_if.cur_mean)));
    end
  endtask

  // stimulus, reset and final verdict
  initial begin
    logic [WSC_RAW_W-1:0]        bus;
    logic signed [WSC_RAW_W-1:0] shunt;
    sign_bias_e                  bias;
    int                          pick;
    smp_if.valid           = 1'b0;
    smp_if.bus_voltage_raw = '0;
    smp_if.shunt_raw       = '0;
    bias                   = BIAS_NONE;
    for (int i = 0; i < WIN; i++) begin
      volt_win[i] = '0;
      cur_win[i]  = '0;
    end
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (dir_rows[k]) begin
      send_sample(dir_rows[k].bus, dir_rows[k].shunt, dir_rows[k].typed, dir_rows[k].want);
    end

    // random samples
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 16 == 0) bias = sign_bias_e'($urandom_range(0, 2));
      calm_tx = (n >= CALM_FIRST && n < CALM_LAST);
      // sender pause until the block has handed back everything
      if (n == DRAIN_AT) begin
        smp_if.valid <= 1'b0;
        wait (stats_due.size() == 0);
        @(posedge clk_i);
      end
      pick = $urandom_range(0, 7);
      case (pick)
        0, 1: begin
          bus   = ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000) ^
                  ($urandom_range(0, 1) ? 16'h0007 : 16'h0000);
          shunt = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
        end
        2, 3: begin
          bus   = 16'($urandom_range(0, 127));
          shunt = 16'(int'($urandom_range(0, 15)) - 8);
        end
        default: begin
          bus   = 16'($urandom);
          shunt = 16'($urandom);
        end
      endcase
      if (bias == BIAS_NEG) shunt[WSC_RAW_W-1] = 1'b1;
      if (bias == BIAS_POS) shunt[WSC_RAW_W-1] = 1'b0;
      send_sample(bus, shunt, 1'b0, NO_STATS);
    end
    smp_if.valid <= 1'b0;

    wait (stats_due.size() == 0);
    repeat (TAIL_LEN) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("window_stats_two_channel regression: pass");
    end else begin
      $display("window_stats_two_channel regression: fail");
    end
    $finish;
  end

  // result side: check each transaction, random stalls, one long hold-off
  initial begin
    stat_if.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (stat_if.valid && stat_if.ready) begin
        check_stats();
        n_results++;
      end
      if (n_results == HOLD_AT && !held_off) begin
        held_off = 1'b1;
        stat_if.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk_i);
      end else begin
        stat_if.ready <= (n_results >= CALM_FIRST && n_results < CALM_LAST) ||
                         ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // watchdog on cycles without any transaction
  int stuck_cycles = 0;
  always @(posedge clk_i) begin
    if ((smp_if.valid && smp_if.ready) || (stat_if.valid && stat_if.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_MAX) begin
      $display("%0t: no transaction for %0d cycles", $time, STUCK_MAX);
      $display("window_stats_two_channel regression: fail");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

endmodule : tb_top

>>> filelist.f
rtl/wsc_pkg.sv
rtl/wsc_if.sv
rtl/wsc_window.sv
rtl/wsc_divider.sv
rtl/window_stats_two_channel.sv
sim/tb_top.sv
